// ===== rtl/core/gbd_pkg.sv =====
package gbd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CodeW  = 32;
  localparam int unsigned CountW = 3;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned PhaseW = 2;

  localparam logic [KindW-1:0] KIND_LINE    = 3'd0;
  localparam logic [KindW-1:0] KIND_SINGLE  = 3'd1;
  localparam logic [KindW-1:0] KIND_GB2312  = 3'd2;
  localparam logic [KindW-1:0] KIND_GB13000 = 3'd3;
  localparam logic [KindW-1:0] KIND_GB18030 = 3'd4;

  localparam logic [ModeW-1:0] MODE_SBCS    = 2'd0;
  localparam logic [ModeW-1:0] MODE_GB2312  = 2'd1;
  localparam logic [ModeW-1:0] MODE_GBK     = 2'd2;
  localparam logic [ModeW-1:0] MODE_GB18030 = 2'd3;

  localparam logic [PhaseW-1:0] PH_LEAD   = 2'd0;
  localparam logic [PhaseW-1:0] PH_FIRST  = 2'd1;
  localparam logic [PhaseW-1:0] PH_SECOND = 2'd2;
  localparam logic [PhaseW-1:0] PH_THIRD  = 2'd3;

  localparam logic [ByteW-1:0] BYTE_LF    = 8'h0a;
  localparam logic [ByteW-1:0] BYTE_SPACE = 8'h20;
  localparam logic [ByteW-1:0] BYTE_DEL   = 8'h7f;
  localparam logic [ByteW-1:0] BYTE_QMARK = 8'h3f;
  localparam logic [ByteW-1:0] GB_LO      = 8'ha1;
  localparam logic [ByteW-1:0] GB_HI      = 8'hfe;
  localparam logic [ByteW-1:0] GBK_LEAD   = 8'h81;
  localparam logic [ByteW-1:0] GBK_TRAIL  = 8'h40;
  localparam logic [ByteW-1:0] DIGIT_LO   = 8'h30;
  localparam logic [ByteW-1:0] DIGIT_HI   = 8'h39;

  localparam logic [CountW-1:0] CNT_NONE = 3'd0;
  localparam logic [CountW-1:0] CNT_ONE  = 3'd1;
  localparam logic [CountW-1:0] CNT_PAIR = 3'd2;
  localparam logic [CountW-1:0] CNT_QUAD = 3'd4;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [KindW-1:0]  kind;
    logic [CodeW-1:0]  code;
  } gbd_result_t;

endpackage

// ===== rtl/core/gbd_decode.sv =====
module gbd_decode (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [gbd_pkg::ByteW-1:0]       in_byte,
  output logic                            in_ready,
  input  logic                            cfg_valid,
  input  logic [gbd_pkg::ModeW-1:0]       cfg_data,
  input  logic                            out_free,
  output logic                            res_load,
  output gbd_pkg::gbd_result_t            res
);
  import gbd_pkg::*;

  logic              byte_valid;
  logic [ByteW-1:0]  byte_reg;
  logic [ModeW-1:0]  mode;
  logic [PhaseW-1:0] phase;
  logic [PhaseW-1:0] phase_next;
  logic [ByteW-1:0]  held [3];
  logic [2:0]        held_we;
  logic              advance;
  logic [ByteW-1:0]  b;

  assign b        = byte_reg;
  assign advance  = byte_valid && out_free;
  assign in_ready = !byte_valid || advance;
  assign res_load = advance;

  always_comb begin
    phase_next = phase;
    held_we    = 3'b000;
    res.count  = CNT_NONE;
    res.kind   = KIND_SINGLE;
    res.code   = {{(CodeW-ByteW){1'b0}}, b};
    unique case (phase)
      PH_LEAD: begin
        if (b == BYTE_LF) begin
          res.count = CNT_ONE;
          res.kind  = KIND_LINE;
          res.code  = '0;
        end else if (b < BYTE_SPACE) begin
          res.count = CNT_NONE;
        end else if (mode == MODE_SBCS || b <= BYTE_DEL) begin
          res.count = CNT_ONE;
        end else if (mode == MODE_GB2312) begin
          if (b >= GB_LO && b <= GB_HI) begin
            held_we[0] = 1'b1;
            phase_next = PH_FIRST;
          end
        end else if (b >= GBK_LEAD && b <= GB_HI) begin
          held_we[0] = 1'b1;
          phase_next = PH_FIRST;
        end
      end
      PH_FIRST: begin
        phase_next = PH_LEAD;
        if (mode == MODE_GB2312) begin
          if (b >= GB_LO && b <= GB_HI) begin
            res.count = CNT_ONE;
            res.kind  = KIND_GB2312;
            res.code  = {{(CodeW-2*ByteW){1'b0}}, held[0], b};
          end else begin
            res.count = CNT_PAIR;
            res.code  = {{(CodeW-ByteW){1'b0}}, BYTE_QMARK};
          end
        end else if (mode == MODE_GB18030 && b >= DIGIT_LO && b <= DIGIT_HI) begin
          held_we[1] = 1'b1;
          phase_next = PH_SECOND;
        end else if ((mode == MODE_GBK || mode == MODE_GB18030) && b >= GBK_TRAIL &&
                     b <= GB_HI && b != BYTE_DEL) begin
          res.count = CNT_ONE;
          res.kind  = KIND_GB13000;
          res.code  = {{(CodeW-2*ByteW){1'b0}}, held[0], b};
        end else begin
          res.count = CNT_PAIR;
          res.code  = {{(CodeW-ByteW){1'b0}}, BYTE_QMARK};
        end
      end
      PH_SECOND: begin
        held_we[2] = 1'b1;
        phase_next = PH_THIRD;
      end
      PH_THIRD: begin
        phase_next = PH_LEAD;
        if (held[2] >= GBK_LEAD && held[2] <= GB_HI && b >= DIGIT_LO && b <= DIGIT_HI) begin
          res.count = CNT_ONE;
          res.kind  = KIND_GB18030;
          res.code  = {held[0], held[1], held[2], b};
        end else begin
          res.count = CNT_QUAD;
          res.code  = {{(CodeW-ByteW){1'b0}}, BYTE_QMARK};
        end
      end
      default: begin
        phase_next = PH_LEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      mode       <= MODE_SBCS;
      phase      <= PH_LEAD;
    end else begin
      if (in_valid && in_ready) begin
        byte_valid <= 1'b1;
      end else if (advance) begin
        byte_valid <= 1'b0;
      end
      if (cfg_valid) begin
        mode  <= cfg_data;
        phase <= PH_LEAD;
      end else if (advance) begin
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_reg <= in_byte;
    end
    for (int i = 0; i < 3; i++) begin
      if (advance && held_we[i]) begin
        held[i] <= b;
      end
    end
  end

endmodule

// ===== rtl/core/gbd_emit.sv =====
module gbd_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_load,
  input  gbd_pkg::gbd_result_t        res,
  output logic                        out_free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gbd_pkg::KindW-1:0]   out_kind,
  output logic [gbd_pkg::CodeW-1:0]   out_code,
  output logic                        out_last
);
  import gbd_pkg::*;

  logic [CountW-1:0] cnt;
  logic [CountW-1:0] cnt_next;
  logic [KindW-1:0]  kind;
  logic [CodeW-1:0]  code;
  logic              fire;

  assign fire      = out_valid && out_ready;
  assign out_valid = (cnt != CNT_NONE);
  assign out_last  = (cnt == CNT_ONE);
  assign out_free  = !out_valid || (out_last && out_ready);
  assign out_kind  = kind;
  assign out_code  = code;

  always_comb begin
    cnt_next = cnt;
    if (res_load) begin
      cnt_next = res.count;
    end else if (fire) begin
      cnt_next = cnt - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CNT_NONE;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      kind <= res.kind;
      code <= res.code;
    end
  end

endmodule

// ===== rtl/core/printer_gb_multibyte_decoder.sv =====
// Printer byte-stream decoder: host bytes in, glyph requests out.
// Input stream s_axis: one raw host byte per transaction in s_axis_tdata.
// Output stream m_axis: one glyph request per transaction; m_axis_tuser carries
// the kind (line, single byte, GB2312, GB13000, GB18030), m_axis_tdata the
// glyph code, and m_axis_tlast marks the last request caused by one byte.
// Configuration: a cfg_valid/cfg_ready transaction writes the encoding mode and
// drops any partial multibyte sequence; write it only while the block is idle.
// Each byte is held in the input register, its requests in the output register.
// Throughput: one byte per cycle, m_axis ready, at most one request per byte.
// An invalid multibyte sequence gives two or four '?' requests, one per
// cycle with m_axis ready; the input register holds the next byte meanwhile.
// Reset (rst, synchronous) empties both registers, sets single-byte mode and
// waits for a lead byte. When the receiver stalls, the current request holds
// on m_axis, at most one more byte is taken into the input register, then
// s_axis_tready drops.
module printer_gb_multibyte_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gbd_pkg::CodeW-1:0]       m_axis_tdata,  // [31:0] glyph_code
  output logic [gbd_pkg::KindW-1:0]       m_axis_tuser,  // [2:0] out_kind
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gbd_pkg::ModeW-1:0]       cfg_data
);
  import gbd_pkg::*;

  logic        out_free;
  logic        res_load;
  gbd_result_t res;

  assign cfg_ready = 1'b1;

  gbd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_byte   (s_axis_tdata),
    .in_ready  (s_axis_tready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res)
  );

  gbd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .out_free  (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_code  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
